FILE: sv/bcm_pkg.sv
`default_nettype none

package bcm_pkg;

  localparam int ADC_BITS_DEFAULT = 12;

  // Field and register widths
  localparam int VOLT_W     = 16;
  localparam int PCT_W      = 7;
  localparam int POWER_W    = 24;
  localparam int BSCALE_W   = 20;
  localparam int SCALE_W    = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // Shared multiplier
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // Rounded voltage sum before the divide by 100: (v >> 16) + 99 * avg + 50
  localparam int QSUM_W = 24;
  localparam int QBASE_W = 23;
  // Weighted percent sum 5 * p + 95 * prev
  localparam int PSUM_W = 14;

  // Divide by 100 as multiply by ceil(2^38 / 100) and shift; exact below 2^31
  localparam logic [MUL_W-1:0] RECIP_100 = 32'd2748779070;
  localparam int RECIP_SHIFT = 38;

  // Motor term reaches the power limit once (v * m) >> 32 hits 100 * 2^24
  localparam logic [PROD_W-1:0] MOTOR_SAT_T = 64'd1677721600;

  localparam logic [VOLT_W-1:0]  VOLT_MAX  = 16'hFFFF;
  localparam logic [POWER_W-1:0] POWER_MAX = 24'hFFFFFF;
  localparam logic [VOLT_W-1:0]  LUT_LOW   = 16'd1350;
  localparam logic [VOLT_W-1:0]  LUT_HIGH  = 16'd1619;
  localparam int LUT_DEPTH = 270;
  localparam int LUT_IDX_W = $clog2(LUT_DEPTH);

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

  localparam logic [BSCALE_W-1:0] BATTERY_SCALE_RESET = 20'd26214;
  localparam logic [SCALE_W-1:0]  RAIL_SCALE_RESET    = 24'd65536;
  localparam logic [SCALE_W-1:0]  MOTOR_SCALE_RESET   = 24'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BATTERY_SCALE,
    REG_RAIL_POWER_SCALE,
    REG_MOTOR_CURRENT_SCALE
  } cfg_reg_t;

  typedef struct packed {
    logic [VOLT_W-1:0] volt;
    logic [PCT_W-1:0]  pct;
  } bcm_state_t;

  localparam bcm_state_t STATE_RESET = '{volt: 16'd1700, pct: 7'd100};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_RAIL,
    ST_MOTOR,
    ST_DIV_VOLT,
    ST_PART0,
    ST_PART1,
    ST_PART2,
    ST_PART3,
    ST_DIV_PCT,
    ST_DIV_MOTOR,
    ST_FINISH
  } seq_state_t;

  // State of charge for 13.50 V .. 16.19 V, one entry per centivolt
  localparam logic [PCT_W-1:0] SOC_ROM [LUT_DEPTH] = '{
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
    7'd1,  7'd1,  7'd1,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,
    7'd3,  7'd3,  7'd3,  7'd3,  7'd3,  7'd3,  7'd4,  7'd4,  7'd4,  7'd4,
    7'd4,  7'd4,  7'd4,  7'd5,  7'd5,  7'd5,  7'd5,  7'd5,  7'd6,  7'd6,
    7'd6,  7'd6,  7'd6,  7'd6,  7'd7,  7'd7,  7'd7,  7'd7,  7'd7,  7'd8,
    7'd8,  7'd8,  7'd8,  7'd8,  7'd9,  7'd9,  7'd9,  7'd9,  7'd9,  7'd10,
    7'd10, 7'd10, 7'd10, 7'd11, 7'd11, 7'd11, 7'd11, 7'd12, 7'd12, 7'd12,
    7'd12, 7'd12, 7'd13, 7'd13, 7'd13, 7'd14, 7'd14, 7'd14, 7'd14, 7'd15,
    7'd15, 7'd15, 7'd16, 7'd16, 7'd16, 7'd17, 7'd17, 7'd17, 7'd18, 7'd18,
    7'd18, 7'd18, 7'd19, 7'd19, 7'd19, 7'd20, 7'd20, 7'd21, 7'd21, 7'd21,
    7'd22, 7'd22, 7'd23, 7'd23, 7'd24, 7'd24, 7'd24, 7'd25, 7'd25, 7'd26,
    7'd26, 7'd27, 7'd27, 7'd28, 7'd28, 7'd29, 7'd29, 7'd30, 7'd30, 7'd31,
    7'd31, 7'd32, 7'd33, 7'd33, 7'd34, 7'd34, 7'd35, 7'd36, 7'd36, 7'd37,
    7'd38, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42, 7'd42, 7'd43, 7'd44, 7'd45,
    7'd46, 7'd47, 7'd48, 7'd51, 7'd52, 7'd54, 7'd55, 7'd57, 7'd59, 7'd61,
    7'd63, 7'd66, 7'd70, 7'd74, 7'd75, 7'd77, 7'd79, 7'd80, 7'd81, 7'd82,
    7'd83, 7'd83, 7'd84, 7'd85, 7'd85, 7'd85, 7'd86, 7'd86, 7'd87, 7'd87,
    7'd87, 7'd88, 7'd88, 7'd88, 7'd89, 7'd89, 7'd89, 7'd89, 7'd90, 7'd90,
    7'd90, 7'd90, 7'd90, 7'd91, 7'd91, 7'd91, 7'd91, 7'd92, 7'd92, 7'd92,
    7'd92, 7'd92, 7'd93, 7'd93, 7'd93, 7'd93, 7'd93, 7'd93, 7'd94, 7'd94,
    7'd94, 7'd94, 7'd94, 7'd94, 7'd94, 7'd95, 7'd95, 7'd95, 7'd95, 7'd95,
    7'd95, 7'd95, 7'd95, 7'd96, 7'd96, 7'd96, 7'd96, 7'd96, 7'd96, 7'd96,
    7'd96, 7'd97, 7'd97, 7'd97, 7'd97, 7'd97, 7'd97, 7'd97, 7'd97, 7'd97,
    7'd97, 7'd97, 7'd98, 7'd98, 7'd98, 7'd98, 7'd98, 7'd98, 7'd98, 7'd98,
    7'd98, 7'd98, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd100, 7'd100,
    7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100
  };

  function automatic logic [PCT_W-1:0] soc_of(input logic [VOLT_W-1:0] cv);
    logic [LUT_IDX_W-1:0] idx;
    idx = LUT_IDX_W'(cv - LUT_LOW);
    if (cv > LUT_HIGH) begin
      return PCT_FULL;
    end else if (cv < LUT_LOW) begin
      return PCT_EMPTY;
    end
    return SOC_ROM[idx];
  endfunction

endpackage

`default_nettype wire

FILE: sv/bcm_state_store.sv
`default_nettype none

module bcm_state_store (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                rd,
  input  wire logic                wr,
  input  wire bcm_pkg::bcm_state_t wr_data,
  output bcm_pkg::bcm_state_t      rd_data
);
  import bcm_pkg::*;

  bcm_state_t mem [1];
  bcm_state_t mem_q;
  logic       written;
  logic       q_written;

  // Until the first write the entry reads as the reset averages.
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= 1'b0;
      q_written <= 1'b0;
    end else begin
      if (wr) begin
        written <= 1'b1;
      end
      if (rd) begin
        q_written <= written;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[0] <= wr_data;
    end
    if (rd) begin
      mem_q <= mem[0];
    end
  end

  assign rd_data = q_written ? mem_q : STATE_RESET;

endmodule

`default_nettype wire

FILE: sv/battery_charge_monitor.sv
// Battery charge monitor: filtered voltage, averaged charge and total power.
// The one shared 32x32 multiplier issues ten products in sequence for each word;
// a new word is taken in only once the last one has reached the output register.
// Reset: rst clears control, restores the scale registers to their defaults
// and marks the state store unwritten, so it reads 17.00 V and 100 percent.
`default_nettype none

module battery_charge_monitor #(
  parameter int ADC_BITS = bcm_pkg::ADC_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_write,
  input  wire logic [bcm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bcm_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ADC_BITS-1:0]               battery_code,
  input  wire logic [ADC_BITS-1:0]               rail_code,
  input  wire logic [ADC_BITS-1:0]               motor_code,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bcm_pkg::VOLT_W-1:0]             filtered_voltage,
  output logic [bcm_pkg::PCT_W-1:0]              charge_percent,
  output logic [bcm_pkg::POWER_W-1:0]            power_mw
);
  import bcm_pkg::*;

  // v = battery_code * battery_scale, m = motor_code * motor_current_scale
  localparam int VW = ADC_BITS + BSCALE_W;
  localparam int MW = ADC_BITS + SCALE_W;
  localparam int AW = VW + MW;
  localparam int TW = AW - MUL_W;

  // Scale registers
  logic [BSCALE_W-1:0] battery_scale;
  logic [SCALE_W-1:0]  rail_power_scale;
  logic [SCALE_W-1:0]  motor_current_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      battery_scale       <= BATTERY_SCALE_RESET;
      rail_power_scale    <= RAIL_SCALE_RESET;
      motor_current_scale <= MOTOR_SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BATTERY_SCALE:       battery_scale <= cfg_data[BSCALE_W-1:0];
        REG_RAIL_POWER_SCALE:    rail_power_scale <= cfg_data[SCALE_W-1:0];
        REG_MOTOR_CURRENT_SCALE: motor_current_scale <= cfg_data[SCALE_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Sequencer and datapath registers
  seq_state_t state, state_next;

  logic [ADC_BITS-1:0] bcode, rcode, mcode;
  logic [QBASE_W-1:0]  qbase;    // 99 * avg + 50
  logic [QSUM_W-1:0]   qsum;     // (v >> 16) + qbase
  logic [VW-1:0]       v;
  logic [MW-1:0]       m;
  logic [AW-1:0]       acc;      // v * m, built from four partial products
  logic [POWER_W-1:0]  rail;
  logic [VOLT_W-1:0]   avg_new;
  logic [PSUM_W-1:0]   psum;     // 5 * p + 95 * prev
  logic [PCT_W-1:0]    pct_new;
  logic                motor_sat;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  logic [PROD_W-1:0] v_wide, m_wide;
  logic [TW-1:0]     t_hi;
  logic [POWER_W:0]  power_sum;
  logic              in_accept;
  logic              fin_go;

  bcm_state_t st_rd_data;
  bcm_state_t st_wr_data;
  logic       st_rd;
  logic       st_wr;

  assign v_wide    = PROD_W'(v);
  assign m_wide    = PROD_W'(m);
  assign t_hi      = acc[AW-1:MUL_W];
  assign in_accept = in_valid && !in_stall;
  // The finishing step waits only while an earlier result is still held.
  assign fin_go    = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_accept) state_next = ST_SCALE;
      ST_SCALE:     state_next = ST_RAIL;
      ST_RAIL:      state_next = ST_MOTOR;
      ST_MOTOR:     state_next = ST_DIV_VOLT;
      ST_DIV_VOLT:  state_next = ST_PART0;
      ST_PART0:     state_next = ST_PART1;
      ST_PART1:     state_next = ST_PART2;
      ST_PART2:     state_next = ST_PART3;
      ST_PART3:     state_next = ST_DIV_PCT;
      ST_DIV_PCT:   state_next = ST_DIV_MOTOR;
      ST_DIV_MOTOR: state_next = ST_FINISH;
      ST_FINISH:    if (fin_go) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer outputs: multiplier operands and state store strobes.
  // Each step from ST_SCALE to ST_DIV_MOTOR issues one product; the following step consumes it from prod.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    in_stall = 1'b1;
    st_rd    = 1'b0;
    st_wr    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        st_rd    = in_valid;
      end
      ST_SCALE: begin
        mul_a = MUL_W'(bcode);
        mul_b = MUL_W'(battery_scale);
      end
      ST_RAIL: begin
        mul_a = MUL_W'(rcode);
        mul_b = MUL_W'(rail_power_scale);
      end
      ST_MOTOR: begin
        mul_a = MUL_W'(mcode);
        mul_b = MUL_W'(motor_current_scale);
      end
      ST_DIV_VOLT: begin
        mul_a = MUL_W'(qsum);
        mul_b = RECIP_100;
      end
      ST_PART0: begin
        mul_a = v_wide[MUL_W-1:0];
        mul_b = m_wide[MUL_W-1:0];
      end
      ST_PART1: begin
        mul_a = v_wide[MUL_W-1:0];
        mul_b = m_wide[PROD_W-1:MUL_W];
      end
      ST_PART2: begin
        mul_a = v_wide[PROD_W-1:MUL_W];
        mul_b = m_wide[MUL_W-1:0];
      end
      ST_PART3: begin
        mul_a = v_wide[PROD_W-1:MUL_W];
        mul_b = m_wide[PROD_W-1:MUL_W];
      end
      ST_DIV_PCT: begin
        mul_a = MUL_W'(psum);
        mul_b = RECIP_100;
      end
      ST_DIV_MOTOR: begin
        mul_a = MUL_W'(t_hi);
        mul_b = RECIP_100;
      end
      ST_FINISH: begin
        st_wr = fin_go;
      end
      default: ;
    endcase
  end

  // Shared multiplier; hold the last product while the result waits
  always_ff @(posedge clk) begin
    if (state != ST_FINISH) begin
      prod <= mul_a * mul_b;
    end
  end

  // Datapath: each step after ST_SCALE consumes the product issued by the step before it
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          bcode <= battery_code;
          rcode <= rail_code;
          mcode <= motor_code;
        end
      end
      ST_SCALE: begin
        // stored average is valid from the read issued at accept
        qbase <= QBASE_W'(st_rd_data.volt) * QBASE_W'(99) + QBASE_W'(50);
      end
      ST_RAIL: begin
        v    <= VW'(prod);
        qsum <= QSUM_W'(prod >> 16) + QSUM_W'(qbase);
      end
      ST_MOTOR: begin
        rail <= POWER_W'(prod >> 16);
      end
      ST_DIV_VOLT: begin
        m <= MW'(prod);
      end
      ST_PART0: begin
        // saturate the rounded average to 16 bits
        if ((prod >> RECIP_SHIFT) > PROD_W'(VOLT_MAX)) begin
          avg_new <= VOLT_MAX;
        end else begin
          avg_new <= VOLT_W'(prod >> RECIP_SHIFT);
        end
      end
      ST_PART1: begin
        acc  <= AW'(prod);
        psum <= PSUM_W'(soc_of(avg_new)) * PSUM_W'(5)
              + PSUM_W'(st_rd_data.pct) * PSUM_W'(95);
      end
      ST_PART2, ST_PART3: begin
        acc <= acc + (AW'(prod) << MUL_W);
      end
      ST_DIV_PCT: begin
        acc <= acc + (AW'(prod) << PROD_W);
      end
      ST_DIV_MOTOR: begin
        pct_new   <= PCT_W'(prod >> RECIP_SHIFT);
        motor_sat <= PROD_W'(t_hi) >= MOTOR_SAT_T;
      end
      ST_FINISH: ;
      default: ;
    endcase
  end

  // Rail power plus motor term; the motor term is below 2^24 unless flagged
  assign power_sum = (POWER_W+1)'(rail) + (POWER_W+1)'(POWER_W'(prod >> RECIP_SHIFT));

  // Output register: hold the word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && fin_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && fin_go) begin
      filtered_voltage <= avg_new;
      charge_percent   <= pct_new;
      if (motor_sat || power_sum[POWER_W]) begin
        power_mw <= POWER_MAX;
      end else begin
        power_mw <= power_sum[POWER_W-1:0];
      end
    end
  end

  // Averages live in a one-entry synchronous store: read at accept,
  // written back as the word finishes, so read and write never overlap.
  assign st_wr_data = '{volt: avg_new, pct: pct_new};

  bcm_state_store u_state (
    .clk     (clk),
    .rst     (rst),
    .rd      (st_rd),
    .wr      (st_wr),
    .wr_data (st_wr_data),
    .rd_data (st_rd_data)
  );

  // The averaged charge never leaves 0..100
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> charge_percent <= PCT_FULL)
    else $error("charge percent above 100");

  // Every accepted word walks the full sequence to the finishing step
  a_seq_len: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> ##10 (state == ST_FINISH))
    else $error("sequencer skipped a step");

  // No word is taken in while the averages are being written back
  a_store_interlock: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> !st_wr)
    else $error("accept collides with state write-back");

endmodule

`default_nettype wire
